### hdl/speq_pkg.sv
// Shared field widths and item codes of the strict-priority event queue.
package speq_pkg;

    localparam int KIND_W = 2;
    localparam int DEV_W  = 4;
    localparam int SEN_W  = 4;
    localparam int PRI_W  = 2;
    localparam int TAG_W  = 16;
    localparam int STAT_W = 3;
    localparam int LVL_W  = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXEC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ATTACH = 2'd2;

    localparam logic [STAT_W-1:0] ST_ADDED     = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_DEVICE = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_SENSOR = 3'd2;
    localparam logic [STAT_W-1:0] ST_EXECUTED  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE      = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd5;
    localparam logic [STAT_W-1:0] ST_ATTACHED  = 3'd6;

    localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

endpackage

### hdl/speq_queue_ram.sv
// Event store: one write port, one read port with registered read data.
module speq_queue_ram
    import speq_pkg::*;
#(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 24
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/strict_priority_event_queue_core.sv
// Strict-priority event queue core: sensor map, three event FIFOs, device power bits.
// Each item passes through the states IDLE, which accepts it, READ, which does the
// registered read of the event store and the sensor map (one port each), and EVAL,
// which evaluates the item, commits its state updates and loads the result register.
// The result register frees as soon as the result is taken; while it is still full the
// commit waits. Reset takes effect at once: the sensor map carries one valid bit per
// device row, so no clearing pass is needed. Every item yields exactly one result.
module strict_priority_event_queue_core
    import speq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_DEVICES = 16,
    parameter int NUM_SENSORS = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [DEV_W-1:0]  s_device_id,
    input  logic [SEN_W-1:0]  s_sensor_id,
    input  logic [PRI_W-1:0]  s_priority_req,
    input  logic [TAG_W-1:0]  s_event_tag,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [TAG_W-1:0]  m_out_tag,
    output logic [DEV_W-1:0]  m_out_device,
    output logic [SEN_W-1:0]  m_out_sensor,
    output logic              m_device_on,
    output logic [LVL_W-1:0]  m_served_level
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int DW = $clog2(NUM_DEVICES);
    localparam int SW = $clog2(NUM_SENSORS);
    localparam int EW = DEV_W + SEN_W + TAG_BITS;
    localparam int AW = LVL_W + QW;
    localparam logic [CW:0]   QD_EXT   = (CW + 1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] QD_COUNT = CW'(QUEUE_DEPTH);
    localparam logic [QW-1:0] QD_LAST  = QW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {IDLE, READ, EVAL} state_t;

    state_t                  state_reg, state_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [DEV_W-1:0]        dev_reg, dev_next;
    logic [SEN_W-1:0]        sen_reg, sen_next;
    logic [PRI_W-1:0]        pri_reg, pri_next;
    logic [TAG_BITS-1:0]     tag_reg, tag_next;
    logic [LVL_W-1:0]        lvl_reg, lvl_next;
    logic [QW-1:0]           head_reg, head_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [QW-1:0]           heads_reg [3];
    logic [QW-1:0]           heads_next [3];
    logic [CW-1:0]           counts_reg [3];
    logic [CW-1:0]           counts_next [3];
    logic [NUM_DEVICES-1:0]  map_valid_reg, map_valid_next;
    logic [NUM_DEVICES-1:0]  power_reg, power_next;
    logic                    m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]       m_status_reg, m_status_next;
    logic [TAG_W-1:0]        m_tag_reg, m_tag_next;
    logic [DEV_W-1:0]        m_dev_reg, m_dev_next;
    logic [SEN_W-1:0]        m_sen_reg, m_sen_next;
    logic                    m_on_reg, m_on_next;
    logic [LVL_W-1:0]        m_lvl_reg, m_lvl_next;

    logic [NUM_SENSORS-1:0]  map_mem [NUM_DEVICES];
    logic [NUM_SENSORS-1:0]  map_rd_reg;
    logic                    map_we;
    logic [NUM_SENSORS-1:0]  map_wdata;

    logic                    q_we;
    logic [AW-1:0]           q_waddr;
    logic [EW-1:0]           q_wdata;
    logic                    q_re;
    logic [AW-1:0]           q_raddr;
    logic [EW-1:0]           q_rdata;

    logic [DW-1:0]           dev_idx;
    logic [SW-1:0]           sen_idx;
    logic                    dev_in_range;
    logic                    sen_in_range;
    logic [NUM_SENSORS-1:0]  row;
    logic [LVL_W-1:0]        exec_lvl;
    logic [LVL_W-1:0]        add_lvl;
    logic [LVL_W-1:0]        rd_lvl;
    logic [CW:0]             tail_sum;
    logic [QW-1:0]           tail;
    logic [QW-1:0]           head_inc;
    logic [DEV_W-1:0]        e_dev;
    logic [SEN_W-1:0]        e_sen;
    logic [TAG_BITS-1:0]     e_tag;
    logic [DW-1:0]           e_dev_idx;
    logic                    e_dev_ok;
    logic                    out_free;
    logic                    commit;

    speq_queue_ram #(
        .ADDR_W(AW),
        .DATA_W(EW)
    ) u_queue_ram (
        .aclk (aclk),
        .we   (q_we),
        .waddr(q_waddr),
        .wdata(q_wdata),
        .re   (q_re),
        .raddr(q_raddr),
        .rdata(q_rdata)
    );

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[dev_idx] <= map_wdata;
        end
        if (state_reg == READ) begin
            map_rd_reg <= map_mem[dev_idx];
        end
    end

    assign dev_idx      = DW'(dev_reg);
    assign sen_idx      = SW'(sen_reg);
    assign dev_in_range = int'(dev_reg) < NUM_DEVICES;
    assign sen_in_range = int'(sen_reg) < NUM_SENSORS;
    assign row          = map_valid_reg[dev_idx] ? map_rd_reg : '0;

    assign exec_lvl = (counts_reg[0] != '0) ? LVL_HIGH :
                      (counts_reg[1] != '0) ? LVL_MED : LVL_LOW;
    assign add_lvl  = (pri_reg == LVL_HIGH || pri_reg == LVL_MED) ? pri_reg : LVL_LOW;
    assign rd_lvl   = (kind_reg == KIND_EXEC) ? exec_lvl : add_lvl;

    assign tail_sum = (CW + 1)'(head_reg) + (CW + 1)'(count_reg);
    assign tail     = (tail_sum >= QD_EXT) ? QW'(tail_sum - QD_EXT) : QW'(tail_sum);
    assign head_inc = (head_reg == QD_LAST) ? '0 : head_reg + QW'(1);

    assign e_dev     = q_rdata[EW-1 -: DEV_W];
    assign e_sen     = q_rdata[TAG_BITS +: SEN_W];
    assign e_tag     = q_rdata[TAG_BITS-1:0];
    assign e_dev_idx = DW'(e_dev);
    assign e_dev_ok  = int'(e_dev) < NUM_DEVICES;

    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == EVAL) && out_free;

    assign q_re    = (state_reg == READ);
    assign q_raddr = {rd_lvl, heads_reg[rd_lvl]};
    assign q_waddr = {lvl_reg, tail};
    assign q_wdata = {dev_reg, sen_reg, tag_reg};

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        dev_next       = dev_reg;
        sen_next       = sen_reg;
        pri_next       = pri_reg;
        tag_next       = tag_reg;
        lvl_next       = lvl_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        heads_next     = heads_reg;
        counts_next    = counts_reg;
        map_valid_next = map_valid_reg;
        power_next     = power_reg;
        m_status_next  = m_status_reg;
        m_tag_next     = m_tag_reg;
        m_dev_next     = m_dev_reg;
        m_sen_next     = m_sen_reg;
        m_on_next      = m_on_reg;
        m_lvl_next     = m_lvl_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        map_we         = 1'b0;
        map_wdata      = row | (NUM_SENSORS'(1) << sen_idx);
        q_we           = 1'b0;

        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    kind_next  = s_kind;
                    dev_next   = s_device_id;
                    sen_next   = s_sensor_id;
                    pri_next   = s_priority_req;
                    tag_next   = TAG_BITS'(s_event_tag);
                    state_next = READ;
                end
            end
            READ: begin
                lvl_next   = rd_lvl;
                head_next  = heads_reg[rd_lvl];
                count_next = counts_reg[rd_lvl];
                state_next = EVAL;
            end
            EVAL: begin
                if (commit) begin
                    m_valid_next  = 1'b1;
                    m_status_next = ST_NONE;
                    m_tag_next    = '0;
                    m_dev_next    = '0;
                    m_sen_next    = '0;
                    m_on_next     = 1'b0;
                    m_lvl_next    = '0;
                    state_next    = IDLE;
                    unique case (kind_reg)
                        KIND_ADD: begin
                            m_dev_next = dev_reg;
                            m_sen_next = sen_reg;
                            priority if (!dev_in_range || row == '0) begin
                                m_status_next = ST_NO_DEVICE;
                            end else if (!sen_in_range || !row[sen_idx]) begin
                                m_status_next = ST_NO_SENSOR;
                            end else if (count_reg >= QD_COUNT) begin
                                m_status_next = ST_FULL;
                            end else begin
                                q_we                 = 1'b1;
                                counts_next[lvl_reg] = count_reg + CW'(1);
                                m_status_next        = ST_ADDED;
                            end
                        end
                        KIND_EXEC: begin
                            if (count_reg != '0) begin
                                heads_next[lvl_reg]  = head_inc;
                                counts_next[lvl_reg] = count_reg - CW'(1);
                                m_status_next        = ST_EXECUTED;
                                m_tag_next           = TAG_W'(e_tag);
                                m_dev_next           = e_dev;
                                m_sen_next           = e_sen;
                                m_lvl_next           = lvl_reg;
                                if (e_dev_ok) begin
                                    power_next[e_dev_idx] = !power_reg[e_dev_idx];
                                    m_on_next             = !power_reg[e_dev_idx];
                                end
                            end
                        end
                        KIND_ATTACH: begin
                            m_dev_next = dev_reg;
                            m_sen_next = sen_reg;
                            priority if (!dev_in_range) begin
                                m_status_next = ST_NO_DEVICE;
                            end else if (!sen_in_range) begin
                                m_status_next = ST_NO_SENSOR;
                            end else begin
                                map_we                  = 1'b1;
                                map_valid_next[dev_idx] = 1'b1;
                                m_status_next           = ST_ATTACHED;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            m_valid_reg   <= 1'b0;
            heads_reg     <= '{default: '0};
            counts_reg    <= '{default: '0};
            map_valid_reg <= '0;
            power_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            heads_reg     <= heads_next;
            counts_reg    <= counts_next;
            map_valid_reg <= map_valid_next;
            power_reg     <= power_next;
            kind_reg      <= kind_next;
            dev_reg       <= dev_next;
            sen_reg       <= sen_next;
            pri_reg       <= pri_next;
            tag_reg       <= tag_next;
            lvl_reg       <= lvl_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            m_status_reg  <= m_status_next;
            m_tag_reg     <= m_tag_next;
            m_dev_reg     <= m_dev_next;
            m_sen_reg     <= m_sen_next;
            m_on_reg      <= m_on_next;
            m_lvl_reg     <= m_lvl_next;
        end
    end

    assign s_ready        = (state_reg == IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_tag      = m_tag_reg;
    assign m_out_device   = m_dev_reg;
    assign m_out_sensor   = m_sen_reg;
    assign m_device_on    = m_on_reg;
    assign m_served_level = m_lvl_reg;

    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        counts_reg[0] <= QD_COUNT && counts_reg[1] <= QD_COUNT && counts_reg[2] <= QD_COUNT)
        else $error("queue count beyond depth");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("item accepted while previous item in flight");

    a_result_on_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid && s_ready)
        else $error("commit did not load result");

    a_none_is_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_NONE |->
            m_out_tag == '0 && m_out_device == '0 && m_out_sensor == '0 &&
            !m_device_on && m_served_level == '0)
        else $error("none-scheduled result carries data");

    a_only_exec_tags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EXECUTED |-> m_out_tag == '0 && !m_device_on)
        else $error("tag or power bit on non-execute result");

endmodule
